/* hw/rtl/plce_pkg.sv */
package plce_pkg;

  typedef enum logic [1:0] {
    FUNC_GET  = 2'd0,
    FUNC_PUT  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_e;

  // One slot's contents as they travel along the chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  prio;
    logic [31:0] expiry;
    logic [31:0] recency;
  } entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic        shift;     // rotate contents one place along the chain
    logic        expire;    // drop the head entry if expired
    logic        load;      // overwrite the head entry with wr_entry
    logic        kill;      // invalidate the head entry
    logic        restamp;   // set head recency to stamp
    logic [31:0] now;
    logic [31:0] stamp;
    entry_t      wr_entry;
  } cell_ctrl_t;

  localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

endpackage

/* hw/rtl/plce_cell.sv */
module plce_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_i,
  input  plce_pkg::cell_ctrl_t ctrl_i,
  input  plce_pkg::entry_t     prev_i,
  output plce_pkg::entry_t     ent_o
);

  logic            valid_q, valid_d;
  plce_pkg::entry_t pay_q, pay_d;

  // Valid bit is reset; payload only matters when valid.
  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    if (ctrl_i.shift) begin
      valid_d = prev_i.valid;
      pay_d   = prev_i;
    end else if (head_i) begin
      if (ctrl_i.expire && valid_q && (pay_q.expiry <= ctrl_i.now)) begin
        valid_d = 1'b0;
      end
      if (ctrl_i.kill) begin
        valid_d = 1'b0;
      end
      if (ctrl_i.restamp) begin
        pay_d.recency = ctrl_i.stamp;
      end
      if (ctrl_i.load) begin
        valid_d = 1'b1;
        pay_d   = ctrl_i.wr_entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    ent_o       = pay_q;
    ent_o.valid = valid_q;
  end

endmodule

/* hw/rtl/priority_lru_cache_with_expiry_top.sv */
// Priority LRU cache with expiry.
// Input items arrive on s_axis (tdata holds func, key, value, priority_req and
// lifetime); each produces exactly one result item on m_axis (found,
// read_value, evicted, evicted_key). The capacity register is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle,
// as the block itself does not enforce this. Entries live in a ring of ENTRIES
// cells that rotates one place a cycle while the controller shifts it; the
// controller looks only at the head cell. A put walks once round dropping
// expired entries and searching for the key and, when the table is full, once
// more choosing the victim. It then rotates to the target slot and writes it,
// clearing the victim on the way when it sits in another slot. A get walks
// once round searching for the key and, on a hit, rotates to that slot; a tick
// or an unused code goes straight to its result. One item is worked on at a
// time, and the block returns to idle after a result has gone before taking
// the next. After reset the table is empty, time and stamp counters are zero
// and the capacity is 8. If the receiver stalls, the result is held in the
// output register and no new item is taken until it has gone.
module priority_lru_cache_with_expiry_top #(
  parameter int ENTRIES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], key[33:2], value[65:34], priority_req[73:66], lifetime[89:74]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], read_value[32:1], evicted[33], evicted_key[65:34]
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  plce_pkg::state_e   state_q, state_d;
  plce_pkg::cell_ctrl_t ctrl;
  plce_pkg::entry_t   ents [ENTRIES];
  plce_pkg::entry_t   ring_in [ENTRIES];

  logic [3:0]  cap_q;
  logic [31:0] now_q, seq_q;
  logic [1:0]  func_q;
  logic [31:0] key_q, val_q;
  logic [7:0]  prio_q;
  logic [15:0] life_q;
  logic [IW-1:0] pos_q, pos_d;     // chain slot currently at the head
  logic [IW:0]   cnt_q, cnt_d;     // cycles spent in a phase
  logic [CW-1:0] occ_q, occ_d;     // valid entries seen after expiry
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_pos_q, hit_pos_d;
  logic          free_q, free_d;
  logic [IW-1:0] free_pos_q, free_pos_d;
  logic          vic_q, vic_d;
  logic [IW-1:0] vic_pos_q, vic_pos_d;
  logic [7:0]    vic_prio_q, vic_prio_d;
  logic [31:0]   vic_rec_q, vic_rec_d;
  logic [31:0]   vic_key_q, vic_key_d;
  logic          do_evict_q, do_evict_d;  // victim still to be cleared on the walk
  logic [IW-1:0] tgt_q, tgt_d;
  logic          o_found_q, o_found_d, o_ev_q, o_ev_d;
  logic [31:0]   o_rd_q, o_rd_d, o_evk_q, o_evk_d;
  logic [CW-1:0] cap_eff;
  logic          head_live;
  logic [32:0]   exp_sum;
  logic [31:0]   exp_sat;
  logic          last;

  // Each cell takes its neighbour's entry; the head entry wraps round to the
  // tail and is dropped on the way when the controller kills it.
  always_comb begin
    for (int i = 0; i < ENTRIES - 1; i++) begin
      ring_in[i] = ents[i + 1];
    end
    ring_in[ENTRIES - 1] = ents[0];
    if (ctrl.kill) begin
      ring_in[ENTRIES - 1].valid = 1'b0;
    end
  end

  // Ring of storage cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    plce_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (g == 0),
      .ctrl_i (ctrl),
      .prev_i (ring_in[g]),
      .ent_o  (ents[g])
    );
  end

  assign s_axis_tready = (state_q == plce_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == plce_pkg::ST_OUT);
  assign m_axis_tdata  = {6'd0, o_evk_q, o_ev_q, o_rd_q, o_found_q};

  // Effective capacity: zero acts as one, clamp at ENTRIES.
  always_comb begin
    if (cap_q == 4'd0) begin
      cap_eff = CW'(1);
    end else if ({28'd0, cap_q} > 32'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign exp_sum   = {1'b0, now_q} + {17'd0, life_q};
  assign exp_sat   = exp_sum[32] ? plce_pkg::TIME_MAX : exp_sum[31:0];
  assign head_live = ents[0].valid && !(ents[0].expiry <= now_q);
  assign last      = (cnt_q == (IW + 1)'(ENTRIES - 1));

  // Next state and scan bookkeeping.
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    occ_d      = occ_q;
    hit_d      = hit_q;
    hit_pos_d  = hit_pos_q;
    free_d     = free_q;
    free_pos_d = free_pos_q;
    vic_d      = vic_q;
    vic_pos_d  = vic_pos_q;
    vic_prio_d = vic_prio_q;
    vic_rec_d  = vic_rec_q;
    vic_key_d  = vic_key_q;
    do_evict_d = do_evict_q;
    tgt_d      = tgt_q;
    unique case (state_q)
      plce_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d  = '0;
          occ_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          vic_d  = 1'b0;
          state_d = (s_axis_tdata[1:0] == plce_pkg::FUNC_GET ||
                     s_axis_tdata[1:0] == plce_pkg::FUNC_PUT) ?
                    plce_pkg::ST_EXPIRE : plce_pkg::ST_WRITE;
        end
      end
      plce_pkg::ST_EXPIRE: begin
        // Walk once round: expire (puts), look for key, lowest free slot (puts).
        if (func_q == plce_pkg::FUNC_GET) begin
          if (ents[0].valid && ents[0].key == key_q && !hit_q) begin
            hit_d = 1'b1;
            hit_pos_d = pos_q;
          end
        end else begin
          if (head_live) begin
            occ_d = occ_q + CW'(1);
            if (ents[0].key == key_q && !hit_q) begin
              hit_d = 1'b1;
              hit_pos_d = pos_q;
            end
          end else if (!free_q || pos_q < free_pos_q) begin
            free_d = 1'b1;
            free_pos_d = pos_q;
          end
        end
        pos_d = (pos_q == IW'(ENTRIES - 1)) ? '0 : pos_q + IW'(1);
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          cnt_d = '0;
          if (func_q == plce_pkg::FUNC_GET || hit_d || occ_d < cap_eff) begin
            state_d = plce_pkg::ST_WRITE;
            tgt_d = hit_d ? hit_pos_d : free_pos_d;
            do_evict_d = 1'b0;
          end else begin
            state_d = plce_pkg::ST_SCAN;
          end
        end
      end
      plce_pkg::ST_SCAN: begin
        // Victim search: lowest priority, then oldest stamp, then lowest slot.
        if (ents[0].valid && (!vic_q || ents[0].prio < vic_prio_q ||
            (ents[0].prio == vic_prio_q && (ents[0].recency < vic_rec_q ||
             (ents[0].recency == vic_rec_q && pos_q < vic_pos_q))))) begin
          vic_d = 1'b1;
          vic_pos_d = pos_q;
          vic_prio_d = ents[0].prio;
          vic_rec_d = ents[0].recency;
          vic_key_d = ents[0].key;
        end
        pos_d = (pos_q == IW'(ENTRIES - 1)) ? '0 : pos_q + IW'(1);
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          cnt_d = '0;
          state_d = plce_pkg::ST_WRITE;
          // Victim slot is freed; insert at lowest free slot. When that is a
          // different slot, the victim is cleared separately on the walk.
          tgt_d = (free_q && free_pos_q < vic_pos_d) ? free_pos_q : vic_pos_d;
          do_evict_d = vic_d && (vic_pos_d != tgt_d);
        end
      end
      plce_pkg::ST_WRITE: begin
        if (func_q == plce_pkg::FUNC_PUT) begin
          // Walk until the victim is cleared and the target is at the head.
          if (pos_q == tgt_q && !do_evict_q) begin
            state_d = plce_pkg::ST_OUT;
          end else begin
            pos_d = (pos_q == IW'(ENTRIES - 1)) ? '0 : pos_q + IW'(1);
            if (do_evict_q && pos_q == vic_pos_q) begin
              do_evict_d = 1'b0;
            end
          end
        end else if (func_q == plce_pkg::FUNC_GET && hit_q) begin
          if (pos_q == hit_pos_q) begin
            state_d = plce_pkg::ST_OUT;
          end else begin
            pos_d = (pos_q == IW'(ENTRIES - 1)) ? '0 : pos_q + IW'(1);
          end
        end else begin
          state_d = plce_pkg::ST_OUT;
        end
      end
      plce_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = plce_pkg::ST_IDLE;
        end
      end
      default: state_d = plce_pkg::ST_IDLE;
    endcase
  end

  // Cell commands and result values.
  always_comb begin
    ctrl = '0;
    ctrl.now   = now_q;
    ctrl.stamp = seq_q;
    ctrl.wr_entry.valid   = 1'b1;
    ctrl.wr_entry.key     = key_q;
    ctrl.wr_entry.value   = val_q;
    ctrl.wr_entry.prio    = prio_q;
    ctrl.wr_entry.expiry  = exp_sat;
    ctrl.wr_entry.recency = seq_q;
    o_found_d = o_found_q;
    o_rd_d    = o_rd_q;
    o_ev_d    = o_ev_q;
    o_evk_d   = o_evk_q;
    unique case (state_q)
      plce_pkg::ST_IDLE: begin
        o_found_d = 1'b0;
        o_rd_d    = plce_pkg::READ_MISS;
        o_ev_d    = 1'b0;
        o_evk_d   = '0;
      end
      plce_pkg::ST_EXPIRE: begin
        ctrl.shift = 1'b1;
        // An expired entry is dropped as it is handed round to the tail.
        if (func_q == plce_pkg::FUNC_PUT && !head_live) begin
          ctrl.kill  = 1'b1;
        end
      end
      plce_pkg::ST_SCAN: begin
        ctrl.shift = 1'b1;
        // The eviction is known once the search has gone round.
        if (last) begin
          o_ev_d  = vic_d;
          o_evk_d = vic_d ? vic_key_d : 32'd0;
        end
      end
      plce_pkg::ST_WRITE: begin
        if (func_q == plce_pkg::FUNC_GET && hit_q) begin
          if (pos_q == hit_pos_q) begin
            ctrl.restamp = 1'b1;
            o_found_d = 1'b1;
            o_rd_d    = ents[0].value;
          end else begin
            ctrl.shift = 1'b1;
          end
        end else if (func_q == plce_pkg::FUNC_PUT) begin
          if (pos_q == tgt_q && !do_evict_q) begin
            ctrl.load = 1'b1;
          end else begin
            ctrl.shift = 1'b1;
            if (do_evict_q && pos_q == vic_pos_q) begin
              ctrl.kill  = 1'b1;
            end
          end
        end
      end
      plce_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plce_pkg::ST_IDLE;
      cap_q   <= 4'd8;
      now_q   <= '0;
      seq_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == plce_pkg::ST_WRITE && state_d == plce_pkg::ST_OUT) begin
        if (func_q == plce_pkg::FUNC_TICK && now_q != plce_pkg::TIME_MAX) begin
          now_q <= now_q + 32'd1;
        end
        if (ctrl.load || ctrl.restamp) begin
          seq_q <= seq_q + 32'd1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tdata[1:0];
      key_q  <= s_axis_tdata[33:2];
      val_q  <= s_axis_tdata[65:34];
      prio_q <= s_axis_tdata[73:66];
      life_q <= s_axis_tdata[89:74];
    end
    occ_q      <= occ_d;
    hit_q      <= hit_d;
    hit_pos_q  <= hit_pos_d;
    free_q     <= free_d;
    free_pos_q <= free_pos_d;
    vic_q      <= vic_d;
    vic_pos_q  <= vic_pos_d;
    vic_prio_q <= vic_prio_d;
    vic_rec_q  <= vic_rec_d;
    vic_key_q  <= vic_key_d;
    do_evict_q <= do_evict_d;
    tgt_q      <= tgt_d;
    o_found_q  <= o_found_d;
    o_rd_q     <= o_rd_d;
    o_ev_q     <= o_ev_d;
    o_evk_q    <= o_evk_d;
  end

`ifndef ASSERT_OFF
  // A result is never offered while an item is being taken.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready and valid together");
  // Stamp counter only advances on the cycle a result is formed.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != $past(seq_q)) |-> (state_q == plce_pkg::ST_OUT))
    else $error("stamp moved outside write");
  // Time never goes backwards.
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q)) else $error("time decreased");
  // A miss never reports a found value.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !o_found_q) |-> (o_rd_q == plce_pkg::READ_MISS))
    else $error("miss with value");
`endif

endmodule

/* tb/priority_lru_cache_with_expiry_top_tb.sv */
`timescale 1ns / 100ps

// Scoreboard: keeps a mirror of the cache table and a queue of predicted results.
class plce_scoreboard;
  bit          slot_valid[8];
  bit [31:0]   slot_key[8];
  bit [31:0]   slot_value[8];
  bit [7:0]    slot_prio[8];
  bit [31:0]   slot_expiry[8];
  bit [31:0]   slot_stamp[8];
  bit [31:0]   now_ticks;
  bit [31:0]   next_stamp;
  bit [3:0]    capacity;
  bit [65:0]   pending_results[$];
  int          errors;
  int          hits;
  int          evictions;
  int          checked;

  function new();
    capacity = 4'd8;
  endfunction

  function int find_slot(bit [31:0] k);
    for (int i = 0; i < 8; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Works out the result of one accepted item and updates the mirror.
  function void note_item(plce_pkg::func_e op, bit [31:0] k, bit [31:0] v,
                          bit [7:0] p, bit [15:0] life);
    bit        found;
    bit [31:0] rd;
    bit        ev;
    bit [31:0] evk;
    int        slot;
    int        victim;
    int        count;
    int        cap;
    bit [32:0] sum;
    bit [31:0] exp_time;
    found = 0; rd = plce_pkg::READ_MISS; ev = 0; evk = '0;
    case (op)
      plce_pkg::FUNC_GET: begin
        slot = find_slot(k);
        if (slot >= 0) begin
          slot_stamp[slot] = next_stamp++;
          found = 1;
          rd = slot_value[slot];
          hits++;
        end
      end
      plce_pkg::FUNC_PUT: begin
        cap = (capacity == 0) ? 1 : (capacity > 8 ? 8 : capacity);
        sum = now_ticks + life;
        exp_time = sum[32] ? plce_pkg::TIME_MAX : sum[31:0];
        for (int i = 0; i < 8; i++)
          if (slot_valid[i] && slot_expiry[i] <= now_ticks) slot_valid[i] = 0;
        slot = find_slot(k);
        if (slot < 0) begin
          count = 0;
          for (int i = 0; i < 8; i++) count += slot_valid[i];
          if (count >= cap) begin
            victim = -1;
            for (int i = 0; i < 8; i++) begin
              if (!slot_valid[i]) continue;
              if (victim < 0 || slot_prio[i] < slot_prio[victim] ||
                  (slot_prio[i] == slot_prio[victim] &&
                   slot_stamp[i] < slot_stamp[victim]))
                victim = i;
            end
            if (victim >= 0) begin
              slot_valid[victim] = 0;
              ev = 1;
              evk = slot_key[victim];
              evictions++;
            end
          end
          for (int i = 0; i < 8; i++)
            if (!slot_valid[i]) begin
              slot = i;
              break;
            end
        end
        if (slot >= 0) begin
          slot_valid[slot] = 1;
          slot_key[slot] = k;
          slot_value[slot] = v;
          slot_prio[slot] = p;
          slot_expiry[slot] = exp_time;
          slot_stamp[slot] = next_stamp++;
        end
      end
      plce_pkg::FUNC_TICK: begin
        if (now_ticks != plce_pkg::TIME_MAX) now_ticks++;
      end
      default: ;
    endcase
    pending_results.push_back({evk, ev, rd, found});
  endfunction

  // Compares one result item with the oldest prediction.
  function void check_result(bit [71:0] data);
    bit [65:0] want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result item, expected none, actual %h", $time, data);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (data[0] !== want[0]) begin
      $display("%0t: found mismatch, expected %0d, actual %0d", $time, want[0], data[0]);
      errors++;
    end
    if (data[32:1] !== want[32:1]) begin
      $display("%0t: read_value mismatch, expected %h, actual %h",
               $time, want[32:1], data[32:1]);
      errors++;
    end
    if (data[33] !== want[33]) begin
      $display("%0t: evicted mismatch, expected %0d, actual %0d", $time, want[33], data[33]);
      errors++;
    end
    if (data[65:34] !== want[65:34]) begin
      $display("%0t: evicted_key mismatch, expected %h, actual %h",
               $time, want[65:34], data[65:34]);
      errors++;
    end
  endfunction
endclass

module priority_lru_cache_with_expiry_top_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // func, key, value, priority_req, lifetime from bit 0 up
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // found, read_value, evicted, evicted_key from bit 0 up
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;

  plce_scoreboard board;
  bit          quiet_stretch;
  bit [31:0]   key_pool[8];

  priority_lru_cache_with_expiry_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver side: random stalls except during the quiet stretch.
  always @(negedge clk_i)
    m_axis_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 23);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  // Sends one item, with a random gap first outside the quiet stretch, and notes it when accepted.
  task automatic send_item(plce_pkg::func_e op, bit [31:0] k, bit [31:0] v, bit [7:0] p,
                           bit [15:0] life);
    @(negedge clk_i);
    while (!quiet_stretch && $urandom_range(99) < 23) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, life, p, v, k, op};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(op, k, v, p, life);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for every prediction to be met, then lets the block return to idle.
  task automatic drain();
    while (board.pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_capacity(bit [3:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.capacity = cap;
  endtask

  // Mostly puts and gets over a small key set so hits, updates and evictions occur.
  task automatic random_item();
    int        pick;
    bit [31:0] k;
    bit [15:0] life;
    pick = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
    case ($urandom_range(3))
      0: life = 16'hFFFF;
      1: life = 16'($urandom());
      default: life = 16'($urandom_range(6));
    endcase
    if (pick < 40)
      send_item(plce_pkg::FUNC_PUT, k, $urandom(),
                8'($urandom_range(1) ? $urandom_range(3) : $urandom()), life);
    else if (pick < 80)
      send_item(plce_pkg::FUNC_GET, k, $urandom(), 8'($urandom()), 16'($urandom()));
    else if (pick < 95)
      send_item(plce_pkg::FUNC_TICK, $urandom(), $urandom(), 8'($urandom()),
                16'($urandom()));
    else
      send_item(plce_pkg::FUNC_NONE, $urandom(), $urandom(), 8'($urandom()),
                16'($urandom()));
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    quiet_stretch = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: misses, extremes, update in place, expiry, ties, capacity.
    send_item(plce_pkg::FUNC_GET, 32'h8000_0000, '0, '0, '0);
    send_item(plce_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF, 16'hFFFF);
    send_item(plce_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 16'h0000);
    send_item(plce_pkg::FUNC_GET, 32'h7FFF_FFFF, '0, '0, '0);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0001, 32'hFFFF_FFFF, 8'h10, 16'd3);
    send_item(plce_pkg::FUNC_GET, 32'h7FFF_FFFF, '0, '0, '0);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0001, 32'h1234_5678, 8'h10, 16'd3);
    send_item(plce_pkg::FUNC_TICK, '0, '0, '0, '0);
    send_item(plce_pkg::FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_item(plce_pkg::FUNC_GET, 32'h0000_0001, '0, '0, '0);
    write_capacity(4'd2);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0002, 32'd2, 8'h10, 16'd100);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0003, 32'd3, 8'h10, 16'd100);
    send_item(plce_pkg::FUNC_GET, 32'h0000_0002, '0, '0, '0);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0004, 32'd4, 8'h10, 16'd100);
    write_capacity(4'd0);
    send_item(plce_pkg::FUNC_PUT, 32'h0000_0005, 32'd5, 8'h80, 16'd100);
    write_capacity(4'd15);
    for (int i = 0; i < 9; i++) send_item(plce_pkg::FUNC_PUT, i + 16, i, 8'h40, 16'd50);

    // Random phases over a range of capacities.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_capacity(4'd1);
        1: write_capacity(4'd8);
        7: write_capacity(4'd0);
        default: write_capacity(4'($urandom()));
      endcase
      quiet_stretch = (phase == 3);
      for (int n = 0; n < 100; n++) random_item();
    end
    quiet_stretch = 1'b0;
    drain();
    $display("Checked %0d results: %0d get hits and %0d evictions across eight capacities.",
             board.checked, board.hits, board.evictions);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
